// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/htwd_pkg.sv =====
package htwd_pkg;

  // field widths
  localparam int OP_W       = 2;
  localparam int NODE_IDX_W = 9;
  localparam int SYM_W      = 32;
  localparam int BYTE_W     = 8;
  localparam int COUNT_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int RUN_W      = 32;
  localparam int ROOT_W     = 10;

  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
  localparam int BIT_CNT_W     = $clog2(BITS_PER_BYTE + 1);

  localparam int MAX_NODES_DEF = 512;

  // register port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [0:0] REG_ROOT_INDEX = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_NODE = 2'd0,
    OP_BEGIN      = 2'd1,
    OP_DATA       = 2'd2,
    OP_END        = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_SYMBOL     = 2'd0,
    ST_EMPTY_DICT = 2'd1,
    ST_EXHAUSTED  = 2'd2,
    ST_FRAME_DONE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_ROOT_CFG,
    RD_FRAME_ROOT,
    RD_CUR
  } rd_sel_t;

  typedef enum logic [1:0] {
    EM_NONE,
    EM_EMPTY,
    EM_SINGLE,
    EM_END
  } emit_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BEGIN,
    S_BEGIN_CHK,
    S_EMIT_EMPTY,
    S_EMIT_SINGLE,
    S_EMIT_END,
    S_DATA_START,
    S_LOAD_ROOT,
    S_WALK,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    node_write;
    rd_sel_t rd_sel;
    logic    begin_latch;
    logic    clr_symbols;
    emit_t   emit;
    logic    load_root_entry;
    logic    walk_start;
    logic    walk_step;
    logic    flush;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic root_empty;
    logic entry_leaf;
    logic sym_zero;
    logic hit;
    logic walk_done;
    logic hold_valid;
    logic out_free;
  } dp_status_t;

endpackage

// ===== sv/htwd_in_if.sv =====
interface htwd_in_if import htwd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       operation;
  logic [NODE_IDX_W-1:0] node_index;
  logic                  node_is_leaf;
  logic [NODE_IDX_W-1:0] left_child;
  logic [NODE_IDX_W-1:0] right_child;
  logic [SYM_W-1:0]      leaf_symbol;
  logic [BYTE_W-1:0]     data_byte;
  logic [COUNT_W-1:0]    expected_symbols;

  modport source (
    output valid, operation, node_index, node_is_leaf, left_child, right_child,
           leaf_symbol, data_byte, expected_symbols,
    input  ready
  );

  modport sink (
    input  valid, operation, node_index, node_is_leaf, left_child, right_child,
           leaf_symbol, data_byte, expected_symbols,
    output ready
  );
endinterface

// ===== sv/htwd_out_if.sv =====
interface htwd_out_if import htwd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SYM_W-1:0]    decoded_symbol;
  logic [RUN_W-1:0]    run_length;
  logic                last;

  modport source (
    output valid, status, decoded_symbol, run_length, last,
    input  ready
  );

  modport sink (
    input  valid, status, decoded_symbol, run_length, last,
    output ready
  );
endinterface

// ===== sv/huffman_tree_walk_decoder_unit.sv =====
// Huffman tree-walk decoder. Node items (operation 0) load a table of
// MAX_NODES entries, each a leaf with a 32-bit symbol or an inner node with
// two child indices; children wrap modulo MAX_NODES and writes at or past
// MAX_NODES are dropped. Table entries have no reset value: a frame must only
// reach entries that were written. A begin item (operation 1) latches the
// root_index register (APB, byte address 0, signed, -1 = empty dictionary)
// and the symbol count; a zero count gives no result, an empty dictionary
// one status-1 result, a single-leaf root one symbol result whose
// run_length is the count. Data bytes (operation 2) are walked LSB first, one
// table read per bit; each leaf gives a status-0 result with run_length 1 and
// restarts at the root, and bits past the final symbol are dropped. End of
// stream (operation 3) gives status 2 if symbols were still pending, else 3,
// and clears the frame. The last flag marks the final result of each input
// item. Items are taken one at a time; a data byte with symbols pending
// fetches the root and the current node, walks its bits and then flushes
// any held symbol. A begin, an end and the walk of a data byte can wait on
// a busy result register, and the walk is paced by the single read port of
// the node table that every bit goes through. The result register lets a
// new item be taken while the previous result waits for its transfer.

module huffman_tree_walk_decoder_unit import htwd_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  htwd_in_if.sink               items,
  htwd_out_if.source            results,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  dp_cmd_t           cmd;
  dp_status_t        st;
  logic              cfg_we;
  logic              reg_hit;
  logic [ROOT_W-1:0] root_index;

  // APB: no wait states; the root register is the only one in the map
  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_ROOT_INDEX);
  assign cfg_we  = psel && penable && pwrite && reg_hit;
  // readback is sign-extended, so -1 (empty dictionary) reads back as -1
  assign prdata  = reg_hit ? {{(APB_DATA_W - ROOT_W){root_index[ROOT_W-1]}}, root_index}
                           : '0;

  // sequencer: one item at a time, stalls the walk on a busy result register
  htwd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .items_valid (items.valid),
    .items_op    (op_t'(items.operation)),
    .items_ready (items.ready),
    .st          (st),
    .cmd         (cmd)
  );

  // node table, walk registers and the result register
  htwd_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .st               (st),
    .node_index       (items.node_index),
    .node_is_leaf     (items.node_is_leaf),
    .left_child       (items.left_child),
    .right_child      (items.right_child),
    .leaf_symbol      (items.leaf_symbol),
    .data_byte        (items.data_byte),
    .expected_symbols (items.expected_symbols),
    .cfg_we           (cfg_we),
    .cfg_wdata        (pwdata[ROOT_W-1:0]),
    .root_index       (root_index),
    .out_ready        (results.ready),
    .out_valid        (results.valid),
    .out_status       (results.status),
    .out_symbol       (results.decoded_symbol),
    .out_run_length   (results.run_length),
    .out_last         (results.last)
  );

endmodule

// ===== sv/htwd_datapath.sv =====
`include "assert_macros.svh"

module htwd_datapath import htwd_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_status_t            st,
  input  logic [NODE_IDX_W-1:0] node_index,
  input  logic                  node_is_leaf,
  input  logic [NODE_IDX_W-1:0] left_child,
  input  logic [NODE_IDX_W-1:0] right_child,
  input  logic [SYM_W-1:0]      leaf_symbol,
  input  logic [BYTE_W-1:0]     data_byte,
  input  logic [COUNT_W-1:0]    expected_symbols,
  input  logic                  cfg_we,
  input  logic [ROOT_W-1:0]     cfg_wdata,
  output logic [ROOT_W-1:0]     root_index,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [STATUS_W-1:0]   out_status,
  output logic [SYM_W-1:0]      out_symbol,
  output logic [RUN_W-1:0]      out_run_length,
  output logic                  out_last
);

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int EW = 1 + 2 * AW + SYM_W;

  // child index modulo table depth, by shifted compare-subtract
  function automatic logic [AW-1:0] wrap_idx(input logic [NODE_IDX_W-1:0] v);
    logic [NODE_IDX_W-1:0] r;
    r = v;
    for (int k = NODE_IDX_W - 1; k >= 0; k--) begin
      if (32'(r) >= (32'(MAX_NODES) << k)) begin
        r = r - NODE_IDX_W'(32'(MAX_NODES) << k);
      end
    end
    return AW'(r);
  endfunction

  // entry: leaf flag, left, right, symbol
  logic [EW-1:0] mem [MAX_NODES];
  logic [EW-1:0] q_entry;

  logic [ROOT_W-1:0]    root_cfg;
  logic [AW-1:0]        frame_root;
  logic [AW-1:0]        cur_idx;
  logic [COUNT_W-1:0]   symbols_left;
  logic [COUNT_W-1:0]   count_q;
  logic [BYTE_W-1:0]    byte_q;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic                 chk;
  logic [AW-1:0]        root_left;
  logic [AW-1:0]        root_right;
  logic                 hold_valid;
  logic [SYM_W-1:0]     hold_sym;

  logic             q_leaf;
  logic [AW-1:0]    q_left;
  logic [AW-1:0]    q_right;
  logic [SYM_W-1:0] q_sym;
  logic [AW-1:0]    root_addr;
  logic             root_empty;
  logic             hit;
  logic             bits_done;
  logic             last_sym;
  logic             walk_done;
  logic             walk_read;
  logic [AW-1:0]    step_left;
  logic [AW-1:0]    step_right;
  logic [AW-1:0]    nxt;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             node_ok;
  logic [AW-1:0]    wr_addr;
  logic [EW-1:0]    wr_entry;
  logic             out_free;
  logic             push_walk;
  logic             push_flush;
  logic             push_emit;

  assign q_leaf  = q_entry[EW-1];
  assign q_left  = q_entry[EW-2 -: AW];
  assign q_right = q_entry[EW-2-AW -: AW];
  assign q_sym   = q_entry[SYM_W-1:0];

  assign root_addr  = AW'(root_cfg[NODE_IDX_W-1:0]);
  assign root_empty = root_cfg[ROOT_W-1] ||
                      (32'(root_cfg[NODE_IDX_W-1:0]) >= 32'(MAX_NODES));

  // walk step: leaf check on the node just reached, then one bit of descent
  assign hit        = chk && q_leaf;
  assign bits_done  = (bit_cnt == BIT_CNT_W'(BITS_PER_BYTE));
  assign last_sym   = (symbols_left == COUNT_W'(1));
  assign walk_done  = hit ? (last_sym || bits_done) : bits_done;
  assign walk_read  = cmd.walk_step && !walk_done;
  assign step_left  = hit ? root_left  : q_left;
  assign step_right = hit ? root_right : q_right;
  assign nxt        = byte_q[bit_cnt[BIT_IDX_W-1:0]] ? step_right : step_left;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur_idx;
    if (walk_read) begin
      rd_en   = 1'b1;
      rd_addr = nxt;
    end else begin
      unique case (cmd.rd_sel)
        RD_NONE:       rd_en = 1'b0;
        RD_ROOT_CFG: begin
          rd_en   = 1'b1;
          rd_addr = root_addr;
        end
        RD_FRAME_ROOT: begin
          rd_en   = 1'b1;
          rd_addr = frame_root;
        end
        RD_CUR: begin
          rd_en   = 1'b1;
          rd_addr = cur_idx;
        end
      endcase
    end
  end

  assign node_ok  = (32'(node_index) < 32'(MAX_NODES));
  assign wr_addr  = AW'(node_index);
  assign wr_entry = {node_is_leaf, wrap_idx(left_child), wrap_idx(right_child), leaf_symbol};

  always_ff @(posedge clk) begin
    if (cmd.node_write && node_ok) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      q_entry <= mem[rd_addr];
    end
  end

  assign out_free   = !out_valid || out_ready;
  assign push_walk  = cmd.walk_step && hit && hold_valid;
  assign push_flush = cmd.flush && hold_valid;
  assign push_emit  = (cmd.emit != EM_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      root_cfg     <= '1;
      frame_root   <= '0;
      cur_idx      <= '0;
      symbols_left <= '0;
      bit_cnt      <= '0;
      chk          <= 1'b0;
      hold_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        root_cfg <= cfg_wdata;
      end
      if (cmd.clr_symbols || cmd.emit == EM_END) begin
        symbols_left <= '0;
      end
      if (cmd.begin_latch) begin
        frame_root   <= root_addr;
        cur_idx      <= root_addr;
        symbols_left <= count_q;
      end
      if (cmd.walk_start) begin
        bit_cnt <= '0;
        chk     <= 1'b0;
      end
      if (cmd.walk_step) begin
        if (hit) begin
          symbols_left <= symbols_left - COUNT_W'(1);
          hold_valid   <= 1'b1;
        end
        if (walk_read) begin
          cur_idx <= nxt;
          bit_cnt <= bit_cnt + BIT_CNT_W'(1);
          chk     <= 1'b1;
        end else if (hit) begin
          cur_idx <= frame_root;
        end
      end
      if (cmd.flush) begin
        hold_valid <= 1'b0;
      end
      if (push_walk || push_flush || push_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      count_q <= expected_symbols;
      byte_q  <= data_byte;
    end
    if (cmd.load_root_entry) begin
      root_left  <= q_left;
      root_right <= q_right;
    end
    if (cmd.walk_step && hit) begin
      hold_sym <= q_sym;
    end
    if (push_emit) begin
      out_last <= 1'b1;
      unique case (cmd.emit)
        EM_NONE: begin
          out_status <= ST_SYMBOL;
        end
        EM_EMPTY: begin
          out_status     <= ST_EMPTY_DICT;
          out_symbol     <= '0;
          out_run_length <= '0;
        end
        EM_SINGLE: begin
          out_status     <= ST_SYMBOL;
          out_symbol     <= q_sym;
          out_run_length <= count_q;
        end
        EM_END: begin
          out_status     <= (symbols_left != '0) ? ST_EXHAUSTED : ST_FRAME_DONE;
          out_symbol     <= '0;
          out_run_length <= '0;
        end
      endcase
    end else if (push_walk || push_flush) begin
      out_status     <= ST_SYMBOL;
      out_symbol     <= hold_sym;
      out_run_length <= RUN_W'(1);
      out_last       <= push_flush;
    end
  end

  assign root_index = root_cfg;

  assign st.count_zero = (count_q == '0);
  assign st.root_empty = root_empty;
  assign st.entry_leaf = q_leaf;
  assign st.sym_zero   = (symbols_left == '0);
  assign st.hit        = hit;
  assign st.walk_done  = walk_done;
  assign st.hold_valid = hold_valid;
  assign st.out_free   = out_free;

  `ASSERT_IMPLIES(a_no_overwrite, (push_walk || push_flush || push_emit) && out_valid, out_ready, "result register overwritten while held")
  `ASSERT_IMPLIES(a_hit_pending, cmd.walk_step && hit, symbols_left != '0, "leaf reached with no symbols pending")
  `ASSERT_IMPLIES(a_cur_in_range, symbols_left != '0, 32'(cur_idx) < 32'(MAX_NODES), "current node beyond table")

endmodule

// ===== sv/htwd_ctrl.sv =====
`include "assert_macros.svh"

module htwd_ctrl import htwd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       items_valid,
  input  op_t        items_op,
  output logic       items_ready,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   walk_go;

  // a second leaf may not overwrite the held symbol until the output can take it
  assign walk_go = !(st.hit && st.hold_valid && !st.out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (items_valid) begin
          unique case (items_op)
            OP_WRITE_NODE: state_next = S_IDLE;
            OP_BEGIN:      state_next = S_BEGIN;
            OP_DATA:       state_next = S_DATA_START;
            OP_END:        state_next = S_EMIT_END;
          endcase
        end
      end
      S_BEGIN: begin
        priority if (st.count_zero) state_next = S_IDLE;
        else if (st.root_empty)     state_next = S_EMIT_EMPTY;
        else                        state_next = S_BEGIN_CHK;
      end
      S_BEGIN_CHK:   state_next = st.entry_leaf ? S_EMIT_SINGLE : S_IDLE;
      S_EMIT_EMPTY,
      S_EMIT_SINGLE,
      S_EMIT_END: begin
        if (st.out_free) state_next = S_IDLE;
      end
      S_DATA_START:  state_next = st.sym_zero ? S_IDLE : S_LOAD_ROOT;
      S_LOAD_ROOT:   state_next = S_WALK;
      S_WALK: begin
        if (walk_go && st.walk_done) state_next = S_FLUSH;
      end
      S_FLUSH: begin
        if (!st.hold_valid || st.out_free) state_next = S_IDLE;
      end
      default:       state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    items_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        items_ready = 1'b1;
        if (items_valid) begin
          cmd.capture    = 1'b1;
          cmd.node_write = (items_op == OP_WRITE_NODE);
        end
      end
      S_BEGIN: begin
        cmd.clr_symbols = 1'b1;
        if (!st.count_zero && !st.root_empty) cmd.rd_sel = RD_ROOT_CFG;
      end
      S_BEGIN_CHK: begin
        cmd.begin_latch = !st.entry_leaf;
      end
      S_EMIT_EMPTY: begin
        if (st.out_free) cmd.emit = EM_EMPTY;
      end
      S_EMIT_SINGLE: begin
        if (st.out_free) cmd.emit = EM_SINGLE;
      end
      S_EMIT_END: begin
        if (st.out_free) cmd.emit = EM_END;
      end
      S_DATA_START: begin
        if (!st.sym_zero) cmd.rd_sel = RD_FRAME_ROOT;
      end
      S_LOAD_ROOT: begin
        cmd.load_root_entry = 1'b1;
        cmd.rd_sel          = RD_CUR;
        cmd.walk_start      = 1'b1;
      end
      S_WALK: begin
        cmd.walk_step = walk_go;
      end
      S_FLUSH: begin
        cmd.flush = st.hold_valid && st.out_free;
      end
      default: begin
        items_ready = 1'b0;
      end
    endcase
  end

  `ASSERT_NEXT(a_flush_exit, state == S_FLUSH && !st.hold_valid, state == S_IDLE, "flush without held symbol did not return to idle")
  `ASSERT_IMPLIES(a_walk_no_stray_read, state == S_WALK, cmd.rd_sel == RD_NONE, "table read requested outside the walk path")

endmodule
